/* design/fifo_queue_with_remove_by_key_assert.svh */
// Assertion macros shared by the queue RTL.
`ifndef FIFO_QUEUE_WITH_REMOVE_BY_KEY_ASSERT_SVH
`define FIFO_QUEUE_WITH_REMOVE_BY_KEY_ASSERT_SVH

`ifndef SYNTHESIS
`define FQRK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("queue assertion failed");
`define FQRK_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("queue forbidden condition seen");
`else
`define FQRK_ASSERT(lbl, prop)
`define FQRK_NEVER(lbl, cond)
`endif

`endif

/* design/fqrk_pkg.sv */
// Shared types and defaults for the handle queue.
package fqrk_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int HANDLE_BITS_DEF = 16;

    typedef enum logic [1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_REM = 2'd2,
        OP_NOP = 2'd3
    } op_t;

    typedef struct packed {
        logic capture;
        logic apply;
        logic enq;
        logic deq;
        logic rem;
    } cell_ctrl_t;

endpackage

/* design/fifo_queue_with_remove_by_key.sv */
// Top level: handle queue in arrival order with enqueue, dequeue and remove by key.
// A taken request sets busy, and done is registered from busy.
// A request is taken only while busy is low. The accepting cycle compares every slot with
// the key at once; the busy cycle runs the hit chain and shifts or loads the cells.
// Reset clears all valid bits and the count; slot contents are not cleared.
// Results cannot be stalled; done marks a result for exactly one cycle.
module fifo_queue_with_remove_by_key #(
    parameter int DEPTH       = fqrk_pkg::DEPTH_DEF,
    parameter int HANDLE_BITS = fqrk_pkg::HANDLE_BITS_DEF,
    localparam int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             opcode,
    input  logic [HANDLE_BITS-1:0] handle,
    output logic                   done,
    output logic [HANDLE_BITS-1:0] out_handle,
    output logic                   out_valid,
    output logic                   removed,
    output logic                   overflow,
    output logic [CNT_W-1:0]       count
);

`include "fifo_queue_with_remove_by_key_assert.svh"

    logic                   busy_reg;
    logic                   busy_next;
    logic                   done_reg;
    logic                   done_next;
    fqrk_pkg::op_t          op_reg;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [HANDLE_BITS-1:0] out_handle_reg;
    logic [HANDLE_BITS-1:0] out_handle_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   removed_reg;
    logic                   removed_next;
    logic                   overflow_reg;
    logic                   overflow_next;

    logic                   accept;
    logic [HANDLE_BITS-1:0] key;
    fqrk_pkg::cell_ctrl_t   ctrl;
    logic [DEPTH-1:0]       valid_vec;
    logic [HANDLE_BITS-1:0] data_arr [DEPTH];
    logic [DEPTH:0]         hit_chain;

    assign accept       = start & ~busy_reg;
    assign key          = busy_reg ? handle_reg : handle;
    assign hit_chain[0] = 1'b0;

    always_comb
    begin
        ctrl         = '0;
        ctrl.capture = accept;
        ctrl.apply   = busy_reg;
        unique case (op_reg)
            fqrk_pkg::OP_ENQ: ctrl.enq = 1'b1;
            fqrk_pkg::OP_DEQ: ctrl.deq = 1'b1;
            fqrk_pkg::OP_REM: ctrl.rem = 1'b1;
            default:          ctrl.enq = 1'b0;
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                   l_valid;
        logic                   r_valid;
        logic [HANDLE_BITS-1:0] r_data;

        if (i == 0)
        begin : g_head
            assign l_valid = 1'b1;
        end
        else
        begin : g_mid_l
            assign l_valid = valid_vec[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign r_valid = 1'b0;
            assign r_data  = '0;
        end
        else
        begin : g_mid_r
            assign r_valid = valid_vec[i+1];
            assign r_data  = data_arr[i+1];
        end

        fqrk_cell #(
            .HANDLE_BITS (HANDLE_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .key         (key),
            .hit_in      (hit_chain[i]),
            .hit_out     (hit_chain[i+1]),
            .left_valid  (l_valid),
            .right_data  (r_data),
            .right_valid (r_valid),
            .data        (data_arr[i]),
            .valid       (valid_vec[i])
        );
    end

    always_comb
    begin
        busy_next       = accept;
        done_next       = busy_reg;
        count_next      = count_reg;
        out_handle_next = '0;
        out_valid_next  = 1'b0;
        removed_next    = 1'b0;
        overflow_next   = 1'b0;
        if (busy_reg)
        begin
            if (ctrl.enq)
            begin
                if (valid_vec[DEPTH-1])
                begin
                    overflow_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            if (ctrl.deq && valid_vec[0])
            begin
                out_handle_next = data_arr[0];
                out_valid_next  = 1'b1;
                count_next      = count_reg - CNT_W'(1);
            end
            if (ctrl.rem && hit_chain[DEPTH])
            begin
                removed_next = 1'b1;
                count_next   = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= fqrk_pkg::op_t'(opcode);
            handle_reg <= handle;
        end
        out_handle_reg <= out_handle_next;
        out_valid_reg  <= out_valid_next;
        removed_reg    <= removed_next;
        overflow_reg   <= overflow_next;
    end

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign out_handle = out_handle_reg;
    assign out_valid  = out_valid_reg;
    assign removed    = removed_reg;
    assign overflow   = overflow_reg;
    assign count      = count_reg;

    `FQRK_ASSERT(a_accept_busy, accept |=> busy_reg)
    `FQRK_ASSERT(a_busy_done, busy_reg |=> (done_reg && !busy_reg))
    `FQRK_NEVER(a_done_while_busy, done_reg && busy_reg)
    `FQRK_ASSERT(a_count_tracks_cells, count_reg == CNT_W'($countones(valid_vec)))
    `FQRK_NEVER(a_one_flag, done_reg && ((out_valid_reg && removed_reg) ||
        (out_valid_reg && overflow_reg) || (removed_reg && overflow_reg)))

endmodule

/* design/fqrk_cell.sv */
// One queue slot: holds a handle and its valid bit, shifts toward the head.
module fqrk_cell #(
    parameter int HANDLE_BITS = fqrk_pkg::HANDLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fqrk_pkg::cell_ctrl_t   ctrl,
    input  logic [HANDLE_BITS-1:0] key,
    input  logic                   hit_in,
    output logic                   hit_out,
    input  logic                   left_valid,
    input  logic [HANDLE_BITS-1:0] right_data,
    input  logic                   right_valid,
    output logic [HANDLE_BITS-1:0] data,
    output logic                   valid
);

    logic [HANDLE_BITS-1:0] data_reg;
    logic [HANDLE_BITS-1:0] data_next;
    logic                   valid_reg;
    logic                   valid_next;
    logic                   match_reg;
    logic                   match_next;
    logic                   shift;
    logic                   load;

    assign hit_out = hit_in | match_reg;
    assign shift   = ctrl.apply & (ctrl.deq | (ctrl.rem & hit_out));
    assign load    = ctrl.apply & ctrl.enq & ~valid_reg & left_valid;

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.capture)
        begin
            match_next = valid_reg && (data_reg == key) && (key != '0);
        end
        data_next  = data_reg;
        valid_next = valid_reg;
        if (shift)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (load)
        begin
            data_next  = key;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

/* dv/fifo_queue_with_remove_by_key_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the handle queue with enqueue, dequeue and remove by key.
module fifo_queue_with_remove_by_key_tb;

    localparam int QDEPTH = fqrk_pkg::DEPTH_DEF;
    localparam int HBITS  = fqrk_pkg::HANDLE_BITS_DEF;
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    typedef logic [HBITS-1:0] handle_t;

    typedef struct packed {
        handle_t          hnd;
        logic             vld;
        logic             rem;
        logic             ovf;
        logic [CNT_W-1:0] cnt;
    } queue_reply_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       opcode;
    handle_t          handle;
    logic             done;
    handle_t          out_handle;
    logic             out_valid;
    logic             removed;
    logic             overflow;
    logic [CNT_W-1:0] count;

    handle_t      shadow_q[$];
    queue_reply_t replies_due[$];
    bit           gaps_on;
    int           fail_count;
    int           n_requests;
    int           n_replies;
    int           n_overflows;
    int           n_hits;
    int           n_empty_deq;

    fifo_queue_with_remove_by_key u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .handle     (handle),
        .done       (done),
        .out_handle (out_handle),
        .out_valid  (out_valid),
        .removed    (removed),
        .overflow   (overflow),
        .count      (count)
    );

    always #6 clk = ~clk;

    function automatic queue_reply_t apply_op(fqrk_pkg::op_t op, handle_t h);
        queue_reply_t r;
        int           idx;
        r   = '0;
        idx = -1;
        case (op)
            fqrk_pkg::OP_ENQ:
            begin
                if (shadow_q.size() >= QDEPTH)
                    r.ovf = 1'b1;
                else
                    shadow_q.push_back(h);
            end
            fqrk_pkg::OP_DEQ:
            begin
                if (shadow_q.size() != 0)
                begin
                    r.hnd = shadow_q.pop_front();
                    r.vld = 1'b1;
                end
            end
            fqrk_pkg::OP_REM:
            begin
                if (h != '0)
                begin
                    for (int i = 0; i < shadow_q.size() && idx < 0; i++)
                    begin
                        if (shadow_q[i] == h)
                            idx = i;
                    end
                    if (idx >= 0)
                    begin
                        shadow_q.delete(idx);
                        r.rem = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.cnt = CNT_W'(shadow_q.size());
        return r;
    endfunction

    function automatic handle_t pick_handle();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50 && shadow_q.size() != 0)
            return shadow_q[$urandom_range(0, shadow_q.size() - 1)];
        if (roll < 75)
            return handle_t'($urandom_range(1, 8));
        if (roll < 90)
            return handle_t'($urandom);
        return (roll < 95) ? handle_t'(0) : '1;
    endfunction

    function automatic fqrk_pkg::op_t pick_op(int enq_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < enq_pct)
            return fqrk_pkg::OP_ENQ;
        if (roll < enq_pct + (95 - enq_pct) / 2)
            return fqrk_pkg::OP_DEQ;
        if (roll < 95)
            return fqrk_pkg::OP_REM;
        return fqrk_pkg::OP_NOP;
    endfunction

    task automatic send_request(fqrk_pkg::op_t op, handle_t h);
        queue_reply_t r;
        if (gaps_on && $urandom_range(0, 99) < 21)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
        @(negedge clk);
        start  <= 1'b1;
        opcode <= op;
        handle <= h;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        r = apply_op(op, h);
        replies_due.push_back(r);
        n_requests++;
        if (r.ovf)
            n_overflows++;
        if (r.rem)
            n_hits++;
        if (op == fqrk_pkg::OP_DEQ && !r.vld)
            n_empty_deq++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (replies_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_empty_queue();
        send_request(fqrk_pkg::OP_DEQ, '0);
        send_request(fqrk_pkg::OP_REM, 16'h0001);
        send_request(fqrk_pkg::OP_NOP, '1);
        wait_drained();
    endtask

    task automatic test_fill_and_specials();
        send_request(fqrk_pkg::OP_ENQ, 16'hFFFF);
        send_request(fqrk_pkg::OP_ENQ, 16'h0000);
        send_request(fqrk_pkg::OP_ENQ, 16'h1234);
        send_request(fqrk_pkg::OP_ENQ, 16'h1234);
        send_request(fqrk_pkg::OP_ENQ, 16'h8000);
        send_request(fqrk_pkg::OP_ENQ, 16'h0001);
        for (int i = 6; i < QDEPTH; i++)
        begin
            send_request(fqrk_pkg::OP_ENQ, handle_t'(16'h0100 + i));
        end
        send_request(fqrk_pkg::OP_ENQ, 16'hBEEF);
        send_request(fqrk_pkg::OP_REM, 16'h0000);
        send_request(fqrk_pkg::OP_REM, 16'h1234);
        send_request(fqrk_pkg::OP_REM, 16'hBEEF);
        send_request(fqrk_pkg::OP_REM, handle_t'(16'h0100 + QDEPTH - 1));
        send_request(fqrk_pkg::OP_NOP, 16'h0000);
        send_request(fqrk_pkg::OP_DEQ, 16'h5555);
        send_request(fqrk_pkg::OP_DEQ, 16'hAAAA);
        wait_drained();
    endtask

    task automatic test_random_mix();
        int enq_pct;
        enq_pct = 50;
        for (int i = 0; i < 360; i++)
        begin
            if (i % 50 == 0)
                enq_pct = 30 + 20 * $urandom_range(0, 2);
            send_request(pick_op(enq_pct), pick_handle());
        end
        wait_drained();
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        for (int i = 0; i < 150; i++)
        begin
            send_request(pick_op(55), pick_handle());
        end
        gaps_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_fill_drain_cycles();
        int roll;
        repeat (6)
        begin
            while (shadow_q.size() < QDEPTH)
            begin
                send_request(fqrk_pkg::OP_ENQ, pick_handle());
            end
            repeat ($urandom_range(1, 2)) send_request(fqrk_pkg::OP_ENQ, handle_t'($urandom));
            while (shadow_q.size() != 0)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    send_request(fqrk_pkg::OP_REM,
                                 shadow_q[$urandom_range(0, shadow_q.size() - 1)]);
                else if (roll < 55)
                    send_request(fqrk_pkg::OP_REM, handle_t'($urandom));
                else
                    send_request(fqrk_pkg::OP_DEQ, handle_t'($urandom));
            end
        end
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        queue_reply_t want;
        if (rst_n && done)
        begin
            n_replies++;
            if (replies_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected reply: hnd %h vld %b rem %b ovf %b cnt %0d",
                             out_handle, out_valid, removed, overflow, count);
            end
            else
            begin
                want = replies_due.pop_front();
                if (out_handle !== want.hnd || out_valid !== want.vld || removed !== want.rem
                    || overflow !== want.ovf || count !== want.cnt)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("reply %0d expected: hnd %h vld %b rem %b ovf %b cnt %0d",
                                 n_replies, want.hnd, want.vld, want.rem, want.ovf,
                                 want.cnt);
                        $display("reply %0d actual:   hnd %h vld %b rem %b ovf %b cnt %0d",
                                 n_replies, out_handle, out_valid, removed, overflow,
                                 count);
                    end
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        clk     = 1'b0;
        rst_n   = 1'b0;
        start   = 1'b0;
        opcode  = fqrk_pkg::OP_NOP;
        handle  = '0;
        gaps_on = 1'b1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_queue();
        test_fill_and_specials();
        test_random_mix();
        test_back_to_back();
        test_fill_drain_cycles();

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Covered %0d requests and %0d replies: %0d dropped on full, %0d key hits,",
                 n_requests, n_replies, n_overflows, n_hits);
        $display("%0d empty dequeues; random sender gaps, a gap-free burst, full-to-empty sweeps",
                 n_empty_deq);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/fqrk_pkg.sv
design/fqrk_cell.sv
design/fifo_queue_with_remove_by_key.sv
dv/fifo_queue_with_remove_by_key_tb.sv
